[src/dpc_pkg.sv]
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants of the debounced pulse counter: register map,
// reset values and the structs that travel between its modules.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // Register file
  localparam int unsigned RegAddrW   = 4;
  localparam int unsigned RegIdxW    = 2;
  localparam int unsigned DataW      = 32;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned MsW        = 16;

  localparam logic [RegIdxW-1:0] REG_ENABLED  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_BOUNCE   = 2'd1;
  localparam logic [RegIdxW-1:0] REG_INTERVAL = 2'd2;

  localparam logic [MsW-1:0] IntervalReset = 16'd1000;

  // Live configuration
  typedef struct packed {
    logic           enabled;
    logic [MsW-1:0] bounce_ms;
    logic [MsW-1:0] interval_ms;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic             interval_due;
    logic             read_done;
    logic [TimeW-1:0] pulse_count;
    logic [TimeW-1:0] duration_ms;
  } result_t;

endpackage

[src/dpc_if.sv]
// ----------------------------------------------------------------------------
// dpc_in_if / dpc_out_if
// Valid/ready channels of the debounced pulse counter: tick items in,
// result items out.
// ----------------------------------------------------------------------------
interface dpc_in_if;
  logic valid;
  logic ready;
  logic falling_edge;
  logic read_request;

  modport source (output valid, output falling_edge, output read_request, input ready);
  modport sink   (input valid, input falling_edge, input read_request, output ready);
endinterface

interface dpc_out_if;
  logic        valid;
  logic        ready;
  logic        interval_due;
  logic        read_done;
  logic [31:0] pulse_count;
  logic [31:0] duration_ms;

  modport source (output valid, output interval_due, output read_done,
                  output pulse_count, output duration_ms, input ready);
  modport sink   (input valid, input interval_due, input read_done,
                  input pulse_count, input duration_ms, output ready);
endinterface

[src/dpc_regs.sv]
// ----------------------------------------------------------------------------
// dpc_regs
// APB register file: enable, bounce time and report interval.
// ----------------------------------------------------------------------------
module dpc_regs import dpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  logic               wr_en;
  logic [RegIdxW-1:0] idx;
  cfg_t               cfg_q;
  cfg_t               cfg_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[RegAddrW-1:2];

  // Decode writes; a zero interval is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ENABLED:  cfg_d.enabled   = pwdata[0];
        REG_BOUNCE:   cfg_d.bounce_ms = pwdata[MsW-1:0];
        REG_INTERVAL: begin
          if (pwdata[MsW-1:0] != '0) cfg_d.interval_ms = pwdata[MsW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled     <= 1'b0;
      cfg_q.bounce_ms   <= '0;
      cfg_q.interval_ms <= IntervalReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ENABLED:  prdata = {{(DataW-1){1'b0}}, cfg_q.enabled};
      REG_BOUNCE:   prdata = {{(DataW-MsW){1'b0}}, cfg_q.bounce_ms};
      REG_INTERVAL: prdata = {{(DataW-MsW){1'b0}}, cfg_q.interval_ms};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[src/dpc_core.sv]
// ----------------------------------------------------------------------------
// dpc_core
// Millisecond clock, edge debounce, pulse count, first-edge and interval
// timestamps; computes one result per accepted tick item.
// ----------------------------------------------------------------------------
module dpc_core import dpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    accept_i,
  input  logic    falling_edge_i,
  input  logic    read_request_i,
  output result_t result_o
);

  logic [TimeW-1:0] now_q, now_d;
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic [TimeW-1:0] count_q, count_d;
  logic [TimeW-1:0] first_q, first_d;
  logic [TimeW-1:0] istart_q, istart_d;

  logic             edge_seen;
  logic             counted;
  logic [TimeW-1:0] since_edge;
  logic [TimeW-1:0] count_new;
  logic [TimeW-1:0] first_new;
  logic [TimeW-1:0] istart_new;
  logic [TimeW-1:0] since_istart;

  always_comb begin
    now_d      = now_q + TimeW'(1);
    edge_seen  = cfg_i.enabled && falling_edge_i;
    since_edge = now_d - last_edge_q;
    counted    = edge_seen && (since_edge > {{(TimeW-MsW){1'b0}}, cfg_i.bounce_ms});

    // Count the edge and take the first-edge stamp
    count_new   = count_q + {{(TimeW-1){1'b0}}, counted};
    first_new   = (counted && (first_q == '0)) ? now_d : first_q;
    last_edge_d = edge_seen ? now_d : last_edge_q;

    // Start the interval if not yet started, then test it
    istart_new   = (cfg_i.enabled && (istart_q == '0)) ? now_d : istart_q;
    since_istart = now_d - istart_new;

    result_o.interval_due = cfg_i.enabled &&
                            (since_istart >= {{(TimeW-MsW){1'b0}}, cfg_i.interval_ms});
    result_o.read_done    = read_request_i;
    result_o.pulse_count  = read_request_i ? count_new : '0;
    result_o.duration_ms  = (read_request_i && (first_new != '0)) ? (now_d - first_new) : '0;

    // Read clears count, first edge and interval start
    count_d  = read_request_i ? '0 : count_new;
    first_d  = read_request_i ? '0 : first_new;
    istart_d = read_request_i ? '0 : istart_new;
  end

  // Advance state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      last_edge_q <= '0;
      count_q     <= '0;
      first_q     <= '0;
      istart_q    <= '0;
    end else if (accept_i) begin
      now_q       <= now_d;
      last_edge_q <= last_edge_d;
      count_q     <= count_d;
      first_q     <= first_d;
      istart_q    <= istart_d;
    end
  end

endmodule

[src/dpc_outreg.sv]
// ----------------------------------------------------------------------------
// dpc_outreg
// Result register: holds one result item until taken, reloads in the same
// cycle the held item leaves.
// ----------------------------------------------------------------------------
module dpc_outreg import dpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    space_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  assign space_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = data_q;

  // Hold valid until the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

[src/debounced_pulse_counter_unit.sv]
// Debounced pulse counter: every tick item advances an internal millisecond
// clock, counts a falling edge when more than bounce_ms have passed since the
// previous edge, and answers with one result item in the cycle after it is
// accepted. A tick item is taken in every cycle, sustained one item per cycle,
// as long as the result register is empty or its item is taken in that cycle;
// the single output register that holds the result sets that figure.
// ----------------------------------------------------------------------------
// debounced_pulse_counter_unit
// Top level: APB registers, counter core and result register.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_unit import dpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dpc_in_if.sink              in_if,
  dpc_out_if.source           out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [RegAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready
);

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    space;
  logic    accept;

  assign in_if.ready = space;
  assign accept      = in_if.valid && space;

  dpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dpc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .accept_i       (accept),
    .falling_edge_i (in_if.falling_edge),
    .read_request_i (in_if.read_request),
    .result_o       (core_res)
  );

  dpc_outreg u_outreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (core_res),
    .space_o  (space),
    .valid_o  (out_if.valid),
    .ready_i  (out_if.ready),
    .result_o (out_res)
  );

  // Drive the result payload
  assign out_if.interval_due = out_res.interval_due;
  assign out_if.read_done    = out_res.read_done;
  assign out_if.pulse_count  = out_res.pulse_count;
  assign out_if.duration_ms  = out_res.duration_ms;

endmodule

[test/dpc_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpc_result_checker
// Watches the tick and result channels and the register port of the
// debounced pulse counter. It keeps its own copy of the millisecond clock,
// the edge bookkeeping and the live configuration, works out the result of
// every accepted tick item and compares it with the result item that the
// block delivers, in order.
// ----------------------------------------------------------------------------
module dpc_result_checker import dpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dpc_in_if                   in_ch,
  dpc_out_if                  out_ch,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [RegAddrW-1:0] paddr_i,
  input  logic [DataW-1:0]    pwdata_i,
  input  logic                pready_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         reads_o,
  output int unsigned         dues_o
);

  localparam int unsigned ReportLimit = 10;

  // Mirrored configuration and counter state
  cfg_t             cfg_mirror;
  logic [TimeW-1:0] ms_clock;
  logic [TimeW-1:0] prev_edge_ms;
  logic [TimeW-1:0] pulse_total;
  logic [TimeW-1:0] first_pulse_ms;
  logic [TimeW-1:0] window_start_ms;

  // Results still owed by the block, oldest first
  result_t owed_results[$];

  // Advance the clock by one tick and work out the result of the tick item
  task automatic count_tick(input logic edge_seen, input logic read_req,
                            output result_t res);
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] since_window;
    res = '0;
    ms_clock = ms_clock + TimeW'(1);
    if (cfg_mirror.enabled && edge_seen) begin
      since_edge = ms_clock - prev_edge_ms;
      if (since_edge > TimeW'(cfg_mirror.bounce_ms)) begin
        pulse_total = pulse_total + TimeW'(1);
        if (first_pulse_ms == '0) begin
          first_pulse_ms = ms_clock;
        end
      end
      // bounced edges still move the previous-edge time
      prev_edge_ms = ms_clock;
    end
    if (cfg_mirror.enabled) begin
      if (window_start_ms == '0) begin
        window_start_ms = ms_clock;
      end
      since_window     = ms_clock - window_start_ms;
      res.interval_due = (since_window >= TimeW'(cfg_mirror.interval_ms));
    end
    if (read_req) begin
      res.read_done   = 1'b1;
      res.pulse_count = pulse_total;
      res.duration_ms = (first_pulse_ms != '0) ? ms_clock - first_pulse_ms : '0;
      pulse_total     = '0;
      first_pulse_ms  = '0;
      window_start_ms = '0;
    end
  endtask

  // Check result items, predict tick items, follow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    result_t fresh;
    if (!rst_ni) begin
      cfg_mirror.enabled     = 1'b0;
      cfg_mirror.bounce_ms   = '0;
      cfg_mirror.interval_ms = IntervalReset;
      ms_clock        = '0;
      prev_edge_ms    = '0;
      pulse_total     = '0;
      first_pulse_ms  = '0;
      window_start_ms = '0;
      owed_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
      results_o    = 0;
      reads_o      = 0;
      dues_o       = 0;
    end else begin
      // compare the delivered result with the oldest one owed
      if (out_ch.valid && out_ch.ready) begin
        got.interval_due = out_ch.interval_due;
        got.read_done    = out_ch.read_done;
        got.pulse_count  = out_ch.pulse_count;
        got.duration_ms  = out_ch.duration_ms;
        results_o++;
        if (got.read_done === 1'b1) reads_o++;
        if (got.interval_due === 1'b1) dues_o++;
        if (owed_results.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit) begin
            $display("[%0t] result item %0d, none owed: due=%0b done=%0b count=%0d dur=%0d",
                     $realtime, results_o, got.interval_due, got.read_done,
                     got.pulse_count, got.duration_ms);
          end
        end else begin
          want = owed_results.pop_front();
          if (got.interval_due !== want.interval_due || got.read_done !== want.read_done ||
              got.pulse_count !== want.pulse_count || got.duration_ms !== want.duration_ms) begin
            mismatches_o++;
            if (mismatches_o <= ReportLimit) begin
              $display("[%0t] result item %0d: expected due=%0b done=%0b count=%0d dur=%0d",
                       $realtime, results_o, want.interval_due, want.read_done,
                       want.pulse_count, want.duration_ms);
              $display("[%0t]                  got due=%0b done=%0b count=%0d dur=%0d",
                       $realtime, got.interval_due, got.read_done,
                       got.pulse_count, got.duration_ms);
            end
          end
        end
      end

      // predict the result of an accepted tick item
      if (in_ch.valid && in_ch.ready) begin
        count_tick(in_ch.falling_edge, in_ch.read_request, fresh);
        owed_results.push_back(fresh);
      end

      // follow register writes; unknown indexes and zero intervals are dropped
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[RegAddrW-1:2])
          REG_ENABLED:  cfg_mirror.enabled   = pwdata_i[0];
          REG_BOUNCE:   cfg_mirror.bounce_ms = pwdata_i[MsW-1:0];
          REG_INTERVAL: begin
            if (pwdata_i[MsW-1:0] != '0) cfg_mirror.interval_ms = pwdata_i[MsW-1:0];
          end
          default: ;
        endcase
      end

      pending_o = owed_results.size();
    end
  end

endmodule

[test/debounced_pulse_counter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_pulse_counter_unit_tb
// Drives tick items and register writes into the debounced pulse counter:
// a short directed run over the bounce, interval and read cases, then
// random phases under changing settings and handshake pressure. The checker
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module debounced_pulse_counter_unit_tb;
  import dpc_pkg::*;

  localparam int unsigned        CycleLimit   = 600000;
  localparam int unsigned        PhaseCount   = 8;
  localparam int unsigned        PhaseTicks   = 238;
  localparam logic [RegIdxW-1:0] REG_UNUSED   = 2'd3;
  localparam logic [MsW-1:0]     MsMax        = 16'hFFFF;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned reads;
  int unsigned dues;

  int unsigned ticks_sent;
  int unsigned settings_used;
  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;

  dpc_in_if  in_if ();
  dpc_out_if out_if ();

  debounced_pulse_counter_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dpc_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .reads_o      (reads),
    .dues_o       (dues)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Give up when the run takes far too long
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("run stopped after %0d cycles with %0d results owed", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Send one tick item, idling first at random; leaves valid high
  task automatic send_tick(input logic edge_seen, input logic read_req);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.falling_edge <= edge_seen;
    in_if.read_request <= read_req;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Hold the tick channel until every owed result has come back
  task automatic drain;
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write one register: setup cycle, then access cycle
  task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write a 16-bit millisecond register with junk in the upper bits
  task automatic ms_write(input logic [RegIdxW-1:0] idx, input logic [MsW-1:0] ms);
    logic [DataW-1:0] word;
    word          = $urandom;
    word[MsW-1:0] = ms;
    reg_write(idx, word);
  endtask

  // Stimulus
  initial begin
    logic [MsW-1:0] bounce_pick;
    logic [MsW-1:0] interval_pick;
    logic [DataW-1:0] en_word;
    int unsigned edge_pct;
    int unsigned read_pct;

    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.falling_edge = 1'b0;
    in_if.read_request = 1'b0;
    out_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cycles             = 0;
    ticks_sent         = 0;
    settings_used      = 1;
    idle_pct           = 0;
    stall_pct          = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: sensor absent, edges ignored, reads still clear
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    drain();

    // Enable with junk upper bits, bounce of 2, interval 3; zero interval and
    // unknown index must both be dropped
    reg_write(REG_ENABLED, 32'hFFFF_FFFF);
    reg_write(REG_BOUNCE, 32'hABCD_0002);
    reg_write(REG_INTERVAL, 32'h0000_0003);
    reg_write(REG_INTERVAL, 32'hFFFF_0000);
    reg_write(REG_UNUSED, 32'h0000_1234);
    settings_used++;
    send_tick(1'b1, 1'b0);   // counted, first edge
    send_tick(1'b1, 1'b0);   // bounce
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);   // gap equals bounce: not counted
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);   // gap above bounce: counted
    send_tick(1'b0, 1'b1);   // read count and duration, restart interval
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    drain();

    // Largest bounce and interval: nothing counts, nothing falls due
    reg_write(REG_BOUNCE, 32'hFFFF_FFFF);
    reg_write(REG_INTERVAL, 32'hFFFF_FFFF);
    settings_used++;
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    drain();

    // No bounce, shortest interval: every edge counts
    ms_write(REG_BOUNCE, '0);
    ms_write(REG_INTERVAL, 16'd1);
    settings_used++;
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    drain();

    // Random phases, each with new settings and one of four idling and stall patterns
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase

      case ($urandom_range(0, 3))
        0:       bounce_pick = '0;
        1:       bounce_pick = MsW'($urandom_range(1, 8));
        2:       bounce_pick = MsW'($urandom_range(9, 300));
        default: bounce_pick = MsMax;
      endcase
      case ($urandom_range(0, 4))
        0:       interval_pick = MsW'($urandom_range(1, 4));
        1:       interval_pick = MsW'($urandom_range(5, 150));
        2:       interval_pick = MsMax;
        3:       interval_pick = '0;
        default: interval_pick = MsW'($urandom_range(1, 40));
      endcase
      en_word    = $urandom;
      en_word[0] = ($urandom_range(0, 5) != 0);
      if (phase == 0) begin
        bounce_pick   = '0;
        interval_pick = 16'd1;
      end else if (phase == 1) begin
        bounce_pick   = MsMax;
        interval_pick = MsMax;
      end else if (phase == 2) begin
        en_word[0] = 1'b0;
      end
      if (phase < 2) en_word[0] = 1'b1;

      reg_write(REG_ENABLED, en_word);
      ms_write(REG_BOUNCE, bounce_pick);
      ms_write(REG_INTERVAL, interval_pick);
      settings_used++;

      edge_pct = $urandom_range(5, 95);
      read_pct = $urandom_range(1, 12);
      for (int unsigned n = 0; n < PhaseTicks; n++) begin
        send_tick($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < read_pct);
        // now and then hold the sender until the block is empty
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    $display("covered %0d tick items under %0d register settings", ticks_sent, settings_used);
    $display("checked %0d result items, %0d reads, %0d interval flags", results, reads, dues);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[debounced_pulse_counter_unit.f]
src/dpc_pkg.sv
src/dpc_if.sv
src/dpc_regs.sv
src/dpc_core.sv
src/dpc_outreg.sv
src/debounced_pulse_counter_unit.sv
test/dpc_result_checker.sv
test/debounced_pulse_counter_unit_tb.sv
